>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSVW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("ssvw port check failed");

// Check a property on every clock edge, reset included.
`define SSVW_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("ssvw reset check failed");

`endif

>>> rtl/ssvw_pkg.sv
package ssvw_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = COL_W + 1;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;
    localparam int ENTRY_W   = 25;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPARITY_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISPARITY_OFFSET = 2'd2;

    localparam logic [11:0] IMAGE_WIDTH_RST = 12'd640;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // One accepted word as it travels to the row buffer.
    typedef struct packed {
        logic             vld;
        logic             pix;
        logic             bank;   // bank being loaded; the other one drains
        logic [COL_W-1:0] wcol;
        logic             emit;
        logic [COL_W-1:0] rcol;
        logic             last;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } ssvw_item_t;

    typedef struct packed {
        ssvw_item_t       item;
        logic             tgt_ok;
        logic [COL_W-1:0] tgt_col;
    } ssvw_access_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       hole;
        logic       last;
    } ssvw_result_t;

endpackage

>>> rtl/ssvw_warp.sv
module ssvw_warp import ssvw_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  ssvw_item_t       in_item,
    input  logic [7:0]       in_depth,
    input  logic [CFG_W-1:0] gain,
    input  logic [CFG_W-1:0] offset,
    input  logic [WID_W-1:0] width,
    output ssvw_access_t     out_acc
);

    localparam int WARP_LAT = 6;
    localparam int RECIP_W  = 34;
    localparam int LO_W     = 16;
    localparam int PHI_W    = 43;
    localparam int PLO_W    = 41;
    localparam int V_W      = 59;
    localparam int FRAC_W   = 40;
    localparam int RND_W    = 20;
    localparam int SH_W     = 11;
    localparam int TGT_W    = ((COL_W > SH_W) ? COL_W : SH_W) + 2;

    localparam logic [RECIP_W-1:0] RECIP_ZERO   = {1'b1, {(RECIP_W-1){1'b0}}};
    localparam logic [SH_W-1:0]    SHIFT_LIMIT  = 11'd2047;

    // round(2^32 / d); depth zero stands for one half
    logic [RECIP_W-1:0] recip_tab [256];

    assign recip_tab[0] = RECIP_ZERO;

    for (genvar g = 1; g < 256; g++) begin : g_recip
        localparam logic [63:0] RecipVal = (((64'd1 << 33) / g) + 64'd1) >> 1;
        assign recip_tab[g] = RecipVal[RECIP_W-1:0];
    end

    ssvw_item_t              item_reg [WARP_LAT];
    logic [RECIP_W-1:0]      recip_reg;
    logic signed [PHI_W-1:0] p_hi_reg;
    logic signed [PLO_W-1:0] p_lo_reg;
    logic [V_W-1:0]          v_reg;
    logic [V_W-1:0]          mag_reg;
    logic                    mag_neg_reg;
    logic [SH_W-1:0]         sh_mag_reg;
    logic                    sh_neg_reg;
    logic                    tgt_ok_reg;
    logic [COL_W-1:0]        tgt_col_reg;

    logic signed [CFG_W-1:0] gain_s;
    logic signed [PHI_W-1:0] p_hi_next;
    logic signed [PLO_W-1:0] p_lo_next;
    logic [V_W-1:0]          v_next;
    logic [V_W-1:0]          mag_next;
    logic [RND_W-1:0]        rnd;
    logic [SH_W-1:0]         sh_mag_next;
    logic [TGT_W-1:0]        tgt;
    logic                    tgt_ok_next;

    assign gain_s = gain;

    always_comb begin
        p_hi_next = gain_s * $signed({1'b0, recip_reg[RECIP_W-1:LO_W]});
        p_lo_next = gain_s * $signed({1'b0, recip_reg[LO_W-1:0]});

        v_next = {p_hi_reg, {LO_W{1'b0}}}
               + {{(V_W-PLO_W){p_lo_reg[PLO_W-1]}}, p_lo_reg}
               + {{(V_W-CFG_W-32){offset[CFG_W-1]}}, offset, 32'b0};

        mag_next = v_reg[V_W-1] ? (~v_reg + V_W'(1)) : v_reg;

        // round half away from zero on the magnitude, then clamp
        rnd = {1'b0, mag_reg[V_W-1:FRAC_W]} + RND_W'(mag_reg[FRAC_W-1]);
        sh_mag_next = (rnd > RND_W'(SHIFT_LIMIT)) ? SHIFT_LIMIT : rnd[SH_W-1:0];

        tgt = TGT_W'(item_reg[4].wcol)
            + (sh_neg_reg ? -TGT_W'(sh_mag_reg) : TGT_W'(sh_mag_reg));
        tgt_ok_next = item_reg[4].vld && item_reg[4].pix && !tgt[TGT_W-1]
                   && (tgt < TGT_W'(width));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WARP_LAT; i++) begin
                item_reg[i] <= '0;
            end
        end else begin
            item_reg[0] <= in_item;
            for (int i = 1; i < WARP_LAT; i++) begin
                item_reg[i] <= item_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        recip_reg   <= recip_tab[in_depth];
        p_hi_reg    <= p_hi_next;
        p_lo_reg    <= p_lo_next;
        v_reg       <= v_next;
        mag_reg     <= mag_next;
        mag_neg_reg <= v_reg[V_W-1];
        sh_mag_reg  <= sh_mag_next;
        sh_neg_reg  <= mag_neg_reg;
        tgt_ok_reg  <= tgt_ok_next;
        tgt_col_reg <= tgt[COL_W-1:0];
    end

    assign out_acc.item    = item_reg[WARP_LAT-1];
    assign out_acc.tgt_ok  = tgt_ok_reg;
    assign out_acc.tgt_col = tgt_col_reg;

endmodule

>>> rtl/ssvw_rowbuf.sv
module ssvw_rowbuf import ssvw_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  ssvw_access_t in_acc,
    output logic         busy,
    output logic         res_vld,
    output ssvw_result_t res
);

    logic             clearing_reg;
    logic [COL_W-1:0] clr_cnt_reg;
    logic [ENTRY_W-1:0] rdata_reg [2];
    logic             res_vld_reg;
    logic             res_last_reg;
    logic             res_bank_reg;
    logic [ENTRY_W-1:0] entry;

    // one port per bank: the draining bank reads and clears, the loading bank writes
    for (genvar k = 0; k < 2; k++) begin : g_bank
        logic [ENTRY_W-1:0] mem [MAX_WIDTH];
        logic [COL_W-1:0]   addr;
        logic               we;
        logic [ENTRY_W-1:0] wdata;
        logic               emit_here;
        logic               pix_here;

        always_comb begin
            emit_here = in_acc.item.vld && in_acc.item.emit && (in_acc.item.bank != 1'(k));
            pix_here  = in_acc.tgt_ok && (in_acc.item.bank == 1'(k));
            if (clearing_reg) begin
                addr  = clr_cnt_reg;
                we    = 1'b1;
                wdata = '0;
            end else if (emit_here) begin
                addr  = in_acc.item.rcol;
                we    = 1'b1;
                wdata = '0;
            end else begin
                addr  = in_acc.tgt_col;
                we    = pix_here;
                wdata = {1'b1, in_acc.item.red, in_acc.item.green, in_acc.item.blue};
            end
        end

        always_ff @(posedge aclk) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg[k] <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            res_vld_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
                if (clr_cnt_reg == COL_W'(MAX_WIDTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            res_vld_reg <= in_acc.item.vld && in_acc.item.emit && !clearing_reg;
        end
    end

    always_ff @(posedge aclk) begin
        res_last_reg <= in_acc.item.last;
        res_bank_reg <= ~in_acc.item.bank;
    end

    assign entry     = rdata_reg[res_bank_reg];
    assign busy      = clearing_reg;
    assign res_vld   = res_vld_reg;
    assign res.red   = entry[23:16];
    assign res.green = entry[15:8];
    assign res.blue  = entry[7:0];
    assign res.hole  = ~entry[ENTRY_W-1];
    assign res.last  = res_last_reg;

endmodule

>>> rtl/shift_sensor_view_warp.sv
// Horizontal view warp for a shifted-sensor virtual camera.
// Input words (s_*) carry one pixel each in raster order, or a drain word
// (s_tuser high) that only pulls one pixel of the pending row out.
// Each pixel moves along its row by round((gain/depth + offset)/256) and lands in
// the loading bank of a two-bank row buffer; later pixels win, columns
// outside the row are dropped. While a row is pending, every input word also
// reads and clears one column of that row, which leaves on m_* with a hole flag
// in m_tuser and m_tlast on its final column.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata while the block idles.
// Throughput: one word per cycle while s_tready is high. A result passes
// through the shift arithmetic (reciprocal table, split multiply, sum,
// magnitude, rounding, target column), a row buffer read and the output
// queue before it shows on m_*.
// Reset: both row banks are cleared one column per cycle, all 2048 columns,
// with s_tready low; configuration writes are still taken then.
// Stall: a 16-deep output queue absorbs results; s_tready drops only while the
// banks are cleared or when results in flight and queued fill the queue.
module shift_sensor_view_warp import ssvw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in, depth_in
    input  logic                 s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // red_out, green_out, blue_out
    output logic                 m_tuser,   // hole_flag
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    logic [11:0]      image_width_reg;
    logic [CFG_W-1:0] gain_reg;
    logic [CFG_W-1:0] offset_reg;

    logic [COL_W-1:0] write_column_reg, write_column_next;
    logic [COL_W-1:0] read_column_reg, read_column_next;
    logic             write_bank_reg, write_bank_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] credit_reg, credit_next;

    ssvw_result_t     fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [WID_W-1:0] eff_width;
    logic             s_acc;
    logic             m_acc;
    logic             is_pix;
    logic             rlast;
    logic             wlast;
    logic             busy;
    logic             res_vld;
    ssvw_item_t       item;
    ssvw_access_t     acc;
    ssvw_result_t     res;
    ssvw_result_t     head;

    always_comb begin
        if (image_width_reg == '0) begin
            eff_width = WID_W'(1);
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            eff_width = WID_W'(MAX_WIDTH);
        end else begin
            eff_width = WID_W'(image_width_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= IMAGE_WIDTH_RST;
            gain_reg        <= '0;
            offset_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:      image_width_reg <= cfg_wdata[11:0];
                REG_DISPARITY_GAIN:   gain_reg        <= cfg_wdata;
                REG_DISPARITY_OFFSET: offset_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !busy && (credit_reg < CNT_W'(FIFO_DEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign is_pix   = (s_tuser == OP_PIXEL);
    assign rlast    = ({1'b0, read_column_reg} + WID_W'(1)) >= eff_width;
    assign wlast    = ({1'b0, write_column_reg} + WID_W'(1)) >= eff_width;

    always_comb begin
        write_column_next = write_column_reg;
        read_column_next  = read_column_reg;
        write_bank_next   = write_bank_reg;
        pending_next      = pending_reg;
        if (s_acc) begin
            if (pending_reg) begin
                if (rlast) begin
                    read_column_next = '0;
                    pending_next     = 1'b0;
                end else begin
                    read_column_next = read_column_reg + COL_W'(1);
                end
            end
            // a finished row swaps banks and becomes the pending one
            if (is_pix) begin
                if (wlast) begin
                    write_column_next = '0;
                    write_bank_next   = ~write_bank_reg;
                    pending_next      = 1'b1;
                    read_column_next  = '0;
                end else begin
                    write_column_next = write_column_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb begin
        credit_next = credit_reg;
        if ((s_acc && pending_reg) && !m_acc) begin
            credit_next = credit_reg + CNT_W'(1);
        end else if (!(s_acc && pending_reg) && m_acc) begin
            credit_next = credit_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_column_reg <= '0;
            read_column_reg  <= '0;
            write_bank_reg   <= 1'b0;
            pending_reg      <= 1'b0;
            credit_reg       <= '0;
        end else begin
            write_column_reg <= write_column_next;
            read_column_reg  <= read_column_next;
            write_bank_reg   <= write_bank_next;
            pending_reg      <= pending_next;
            credit_reg       <= credit_next;
        end
    end

    always_comb begin
        item.vld   = s_acc;
        item.pix   = is_pix;
        item.bank  = write_bank_reg;
        item.wcol  = write_column_reg;
        item.emit  = pending_reg;
        item.rcol  = read_column_reg;
        item.last  = rlast;
        item.red   = s_tdata[7:0];
        item.green = s_tdata[15:8];
        item.blue  = s_tdata[23:16];
    end

    ssvw_warp u_warp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (item),
        .in_depth (s_tdata[31:24]),
        .gain     (gain_reg),
        .offset   (offset_reg),
        .width    (eff_width),
        .out_acc  (acc)
    );

    ssvw_rowbuf u_rowbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_acc  (acc),
        .busy    (busy),
        .res_vld (res_vld),
        .res     (res)
    );

    always_comb begin
        count_next = count_reg;
        if (res_vld && !m_acc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!res_vld && m_acc) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (res_vld) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_vld) begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head.blue, head.green, head.red};
    assign m_tuser  = head.hole;
    assign m_tlast  = head.last;

endmodule

>>> rtl/ssvw_checker.sv
`include "assert_macros.svh"

module ssvw_checker import ssvw_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    `SSVW_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid)
    `SSVW_ASSERT(a_m_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `SSVW_ASSERT(a_hole_black, m_tvalid && m_tuser |-> m_tdata == '0)
    `SSVW_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid)
    `SSVW_ASSERT_RST(a_rst_clear, $rose(aresetn) |-> !s_tready)

endmodule

bind shift_sensor_view_warp ssvw_checker u_checker (.*);
